// File: design/lius_pkg.sv
// ----------------------------------------------------------------------------
// lius_pkg
// Shared types and constants for the linear interpolation audio upsampler.
// ----------------------------------------------------------------------------
package lius_pkg;

  localparam int unsigned SampleW  = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned OutDepth = 2;

  typedef enum logic [1:0] {
    ModePlain = 2'd0,
    ModeX2    = 2'd1,
    ModeX4    = 2'd2,
    ModeRsvd  = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMode = 1'b0,
    RegSkip = 1'b1
  } reg_e;

  // One classified sample handed from the front to the slot sequencer
  typedef struct packed {
    logic [SampleW-1:0] old_smp;
    logic [SampleW-1:0] new_smp;
    logic [1:0]         last_idx;
    logic               quarter;
    logic               skip;
  } cmd_t;

  // One DAC slot
  typedef struct packed {
    logic [SampleW-1:0] value;
    logic               strobe;
    logic               last;
  } slot_t;

endpackage

// File: design/lius_fifo.sv
// ----------------------------------------------------------------------------
// lius_fifo
// Small register FIFO with full/empty flags and a combinational head.
// ----------------------------------------------------------------------------
module lius_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: design/lius_front.sv
// ----------------------------------------------------------------------------
// lius_front
// Holds the configuration and the previous sample, and turns each accepted
// sample into a slot command for the sequencer.
// ----------------------------------------------------------------------------
module lius_front import lius_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push_i,
  input  logic [SampleW-1:0]  sample_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output cmd_t                cmd_o
);

  mode_e              mode_q;
  logic               skip_q;
  logic [SampleW-1:0] prev_q;

  assign q_push_o = push_i & ~q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePlain;
      skip_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        RegMode: mode_q <= mode_e'(cfg_data_i[1:0]);
        RegSkip: skip_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (q_push_o) begin
      prev_q <= sample_i;
    end
  end

  always_comb begin
    cmd_o.old_smp = prev_q;
    cmd_o.new_smp = sample_i;
    cmd_o.skip    = skip_q;
    unique case (mode_q)
      ModeX2: begin
        cmd_o.last_idx = 2'd1;
        cmd_o.quarter  = 1'b0;
      end
      ModeX4: begin
        cmd_o.last_idx = 2'd3;
        cmd_o.quarter  = 1'b1;
      end
      // reserved mode passes through like plain
      default: begin
        cmd_o.last_idx = 2'd0;
        cmd_o.quarter  = 1'b0;
      end
    endcase
  end

endmodule

// File: design/lius_back.sv
// ----------------------------------------------------------------------------
// lius_back
// Slot sequencer: walks the slots of the head command, one per cycle while the
// result queue has room, interpolates the value and marks duplicates.
// ----------------------------------------------------------------------------
module lius_back import lius_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cmd_valid_i,
  input  cmd_t  cmd_i,
  input  logic  out_full_i,
  output logic  cmd_pop_o,
  output logic  slot_push_o,
  output slot_t slot_o
);

  logic [1:0]         cnt_q, cnt_d;
  logic [SampleW-1:0] last_q;
  logic               go, is_last;
  logic [SampleW+1:0] o_w, n_w, sum_on, sum_3o, sum_3n;
  logic [SampleW-1:0] value;

  assign go      = cmd_valid_i & ~out_full_i;
  assign is_last = (cnt_q == cmd_i.last_idx);

  assign o_w    = {2'b00, cmd_i.old_smp};
  assign n_w    = {2'b00, cmd_i.new_smp};
  assign sum_on = o_w + n_w;
  assign sum_3o = (o_w << 1) + o_w + n_w;
  assign sum_3n = (n_w << 1) + n_w + o_w;

  always_comb begin
    if (is_last) begin
      value = cmd_i.new_smp;
    end else if (cmd_i.quarter && cnt_q == 2'd0) begin
      value = sum_3o[SampleW+1:2];
    end else if (cmd_i.quarter && cnt_q == 2'd2) begin
      value = sum_3n[SampleW+1:2];
    end else begin
      value = sum_on[SampleW:1];
    end
  end

  assign slot_push_o   = go;
  assign cmd_pop_o     = go & is_last;
  assign slot_o.value  = value;
  assign slot_o.strobe = ~(cmd_i.skip && value == last_q);
  assign slot_o.last   = is_last;

  always_comb begin
    cnt_d = cnt_q;
    if (go) begin
      cnt_d = is_last ? 2'd0 : cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      // track the value of the most recent slot for duplicate compare
      if (go) begin
        last_q <= value;
      end
    end
  end

endmodule

// File: design/linear_interp_audio_upsampler_core.sv
// Path: a sample accepted on the input side is registered in the command queue;
// the slot sequencer then writes its slots into the slot queue, whose head
// is the result side.
// Throughput: one slot per cycle from the slot sequencer while the slot queue
// has room; 1, 2 or 4 slots per sample in plain, two times and four times mode.
// Reset: both queues empty, mode plain, skipping off, previous sample zero.
// ----------------------------------------------------------------------------
// linear_interp_audio_upsampler_core
// Front classifies samples into slot commands, a short queue decouples it from
// the slot sequencer, which fills the result queue.
// ----------------------------------------------------------------------------
module linear_interp_audio_upsampler_core import lius_pkg::*; #(
  parameter int unsigned CmdQDepth = CmdDepth,
  parameter int unsigned OutQDepth = OutDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic [SampleW-1:0]  sample_in_i,
  output logic                empty,
  input  logic                pop,
  output logic [SampleW-1:0]  dac_value_o,
  output logic                write_strobe_o,
  output logic                slot_last_o
);

  cmd_t  cmd_in, cmd_head;
  slot_t slot_in, slot_head;
  logic  cmd_push, cmd_pop, cmd_empty;
  logic  slot_push, out_full;

  lius_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .sample_i   (sample_in_i),
    .q_full_i   (full),
    .q_push_o   (cmd_push),
    .cmd_o      (cmd_in)
  );

  lius_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdQDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .full_o  (full),
    .empty_o (cmd_empty)
  );

  lius_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (~cmd_empty),
    .cmd_i       (cmd_head),
    .out_full_i  (out_full),
    .cmd_pop_o   (cmd_pop),
    .slot_push_o (slot_push),
    .slot_o      (slot_in)
  );

  lius_fifo #(
    .Width ($bits(slot_t)),
    .Depth (OutQDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (slot_push),
    .data_i  (slot_in),
    .pop_i   (pop),
    .data_o  (slot_head),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign dac_value_o    = slot_head.value;
  assign write_strobe_o = slot_head.strobe;
  assign slot_last_o    = slot_head.last;

endmodule

// File: design/lius_checker.sv
// ----------------------------------------------------------------------------
// lius_checker
// Port-level checks for the upsampler, bound to the top level.
// ----------------------------------------------------------------------------
module lius_checker import lius_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [CfgIdxW-1:0]  cfg_idx_i,
  input logic [CfgDataW-1:0] cfg_data_i,
  input logic                empty,
  input logic                pop,
  input logic [SampleW-1:0]  dac_value_o,
  input logic                write_strobe_o,
  input logic                slot_last_o
);

  mode_e mode_q;
  logic  skip_q;

  // shadow the configuration as seen on the write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePlain;
      skip_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegMode) begin
        mode_q <= mode_e'(cfg_data_i[1:0]);
      end else begin
        skip_q <= cfg_data_i[0];
      end
    end
  end

  a_empty_after_reset: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> empty)
    else $error("result side not empty after reset");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(dac_value_o) && $stable(slot_last_o))
    else $error("stalled slot changed");

  a_skip_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !write_strobe_o |-> skip_q)
    else $error("slot skipped with duplicate skipping off");

  a_plain_single_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (mode_q == ModePlain || mode_q == ModeRsvd) |-> slot_last_o)
    else $error("pass-through mode produced more than one slot");

endmodule

bind linear_interp_audio_upsampler_core lius_checker u_lius_checker (.*);
